FILE: src/rbog_pkg.sv
`timescale 1ns / 1ps

package rbog_pkg;

  // Sizing of the format
  localparam int MAX_SECTORS = 65536;
  localparam int START_GROUP = 256;
  localparam int PHASES      = 9;
  localparam int ALIGN       = 256;

  localparam int ADDR_W      = $clog2(MAX_SECTORS);
  localparam int SECT_W      = ADDR_W + 1;
  localparam int START_SHIFT = $clog2(START_GROUP);
  localparam int GSH_W       = $clog2(START_SHIFT + 1);
  localparam int LEN_W       = START_SHIFT + 1;
  localparam int PH_W        = $clog2(PHASES + 2);
  localparam int RAND_W      = 32;
  localparam int DIV_CNT_W   = $clog2(RAND_W);
  localparam int STAT_W      = 2;
  localparam int ODATA_W     = ((ADDR_W + LEN_W + PH_W + 7) / 8) * 8;

  // Reciprocal for division of the format length by the phase count
  localparam int RECIP_SH    = SECT_W + 3;
  localparam int RECIP       = ((2 ** RECIP_SH) + PHASES - 1) / PHASES;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  typedef logic [SECT_W-1:0]  count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [PH_W-1:0]    phase_t;
  typedef logic [GSH_W-1:0]   gshift_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [PADDR_W-3:0] reg_idx_t;

  localparam count_t   TOTAL_RESET = count_t'(MAX_SECTORS);
  localparam reg_idx_t REG_TOTAL   = reg_idx_t'(0);

  // Result status codes
  localparam status_t STAT_OK   = status_t'(0);
  localparam status_t STAT_ERR  = status_t'(1);
  localparam status_t STAT_DONE = status_t'(2);

  // One finished result before it goes out
  typedef struct packed {
    addr_t   addr;
    len_t    len;
    status_t status;
    logic    last;
  } res_t;

endpackage

FILE: src/random_block_order_generator.sv
`timescale 1ns / 1ps

// Random-order block address generator for a device format.
// Input stream (s_*): each transfer carries a 32-bit random word in s_tdata.
// Output stream (m_*): one transfer per input: first sector, block length and
// phase in m_tdata, status in m_tuser, and m_tlast on the block that ends the
// format. Configuration: one APB register at offset 0, total_sectors; writing
// it restarts the format.
// Each item runs through the 32-step modulo divider and then through the sector
// table's single read port, which checks and then moves one entry per cycle.
// Finished or halted items skip both and go straight to the result register.
// One item is worked on at a time; the next is taken while a result still
// waits in the output register.
// Reset and every write of total_sectors run a restart and a fill of the table's
// first F entries, F being the format length in sectors (up to 65536), during
// which no input is taken. A stalled receiver holds the result register; the
// block then finishes the next item and waits with it until the register frees up.

module random_block_order_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [31:0] rand_value
  input  logic [rbog_pkg::RAND_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [15:0] sector_addr, [24:16] block_sectors, [28:25] phase_number, rest zero
  output logic [rbog_pkg::ODATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [rbog_pkg::STAT_W-1:0]  m_tuser,
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbog_pkg::PADDR_W-1:0] paddr,
  input  logic [rbog_pkg::PDATA_W-1:0] pwdata,
  output logic [rbog_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  import rbog_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_INIT2  = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_IDLE   = 4'd3;
  localparam logic [3:0] ST_PHASE  = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_POS    = 4'd6;
  localparam logic [3:0] ST_CHECK  = 4'd7;
  localparam logic [3:0] ST_MOVE   = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state;
  count_t     total_sectors;

  // Format state
  count_t  remaining;
  gshift_t gshift;
  phase_t  phases_left;
  logic    error_flag;
  count_t  q_unit;
  count_t  thr;
  count_t  clr_cnt;

  // Per-item working registers
  logic [RAND_W-1:0]    rnd;
  count_t               rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  addr_t                pos;
  addr_t                tail;
  addr_t                first;
  len_t                 iss;
  len_t                 rd_k;
  logic                 rd_pend;
  res_t                 res;

  // Derived values
  count_t              t_clamp;
  count_t              fmt_len;
  logic [2*SECT_W-1:0] q_prod;
  count_t              groups;
  len_t                len;
  logic [SECT_W:0]     trial;
  logic                iss_active;
  logic                rd_last;
  logic                mismatch;
  phase_t              phase_out;
  logic                cfg_wr;
  logic                cfg_total;
  logic                out_load;
  reg_idx_t            reg_idx;

  // Table memory ports
  logic  ram_we;
  addr_t ram_waddr;
  addr_t ram_wdata;
  addr_t ram_raddr;
  addr_t ram_rdata;

  // Format length: clamp, then round down to whole groups
  assign t_clamp = (total_sectors > count_t'(MAX_SECTORS)) ? count_t'(MAX_SECTORS)
                                                            : total_sectors;
  assign fmt_len = t_clamp & ~count_t'(ALIGN - 1);
  assign q_prod  = (2*SECT_W)'(fmt_len) * (2*SECT_W)'(RECIP);

  assign groups     = remaining >> gshift;
  assign len        = len_t'(1) << gshift;
  assign trial      = {rem, rnd[RAND_W-1]};
  assign iss_active = (iss < len);
  assign rd_last    = rd_pend && (rd_k == len - len_t'(1));
  assign mismatch   = (rd_k != '0) &&
                      (count_t'(ram_rdata) != count_t'(first) + count_t'(rd_k));
  assign phase_out  = phase_t'(PHASES + 1) - phases_left;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_total = cfg_wr && (reg_idx == REG_TOTAL);
  assign prdata    = (reg_idx == REG_TOTAL) ? PDATA_W'(total_sectors) : '0;

  assign s_tready = (state == ST_IDLE);

  // Result register load: finished item, a free (or freeing) register, no config write
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready) && !cfg_total;

  // Memory port selection: fill pass, reads of the picked group, or the copy of the tail group
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos + addr_t'(rd_k);
    ram_wdata = ram_rdata;
    ram_raddr = pos + addr_t'(iss);
    case (state)
      ST_CLEAR: begin
        ram_we    = (clr_cnt < fmt_len);
        ram_waddr = addr_t'(clr_cnt);
        ram_wdata = addr_t'(clr_cnt);
      end
      ST_MOVE: begin
        ram_we    = rd_pend;
        ram_raddr = tail + addr_t'(iss);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rbog_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(MAX_SECTORS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      total_sectors <= TOTAL_RESET;
      m_tvalid      <= 1'b0;
      error_flag    <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_total) begin
        total_sectors <= pwdata[SECT_W-1:0];
        state         <= ST_INIT;
      end else begin
        case (state)
          // Restart: format state and reciprocal quotient
          ST_INIT: begin
            remaining   <= fmt_len;
            gshift      <= gshift_t'(START_SHIFT);
            phases_left <= phase_t'(PHASES);
            error_flag  <= 1'b0;
            q_unit      <= count_t'(q_prod >> RECIP_SH);
            clr_cnt     <= '0;
            state       <= ST_INIT2;
          end
          ST_INIT2: begin
            thr   <= count_t'(q_unit * (PHASES - 1));
            state <= ST_CLEAR;
          end
          // Fill the table with the identity
          ST_CLEAR: begin
            if (clr_cnt < fmt_len) begin
              clr_cnt <= clr_cnt + count_t'(1);
            end else begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              rnd        <= s_tdata;
              res.addr   <= '0;
              res.len    <= '0;
              res.last   <= 1'b0;
              if (error_flag) begin
                res.status <= STAT_ERR;
                state      <= ST_FINISH;
              end else if (remaining == '0) begin
                res.status <= STAT_DONE;
                state      <= ST_FINISH;
              end else begin
                state <= ST_PHASE;
              end
            end
          end
          // Phase boundary: halve the group size
          ST_PHASE: begin
            if (phases_left > phase_t'(1) && remaining <= thr) begin
              if (gshift != '0) begin
                gshift <= gshift - gshift_t'(1);
              end
              phases_left <= phases_left - phase_t'(1);
              thr         <= thr - q_unit;
            end
            rem     <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
          // Restoring modulo, one bit of the random word per cycle
          ST_DIV: begin
            if (trial >= {1'b0, groups}) begin
              rem <= count_t'(trial - {1'b0, groups});
            end else begin
              rem <= count_t'(trial);
            end
            rnd     <= {rnd[RAND_W-2:0], 1'b0};
            div_cnt <= div_cnt + DIV_CNT_W'(1);
            if (div_cnt == DIV_CNT_W'(RAND_W - 1)) begin
              state <= ST_POS;
            end
          end
          ST_POS: begin
            pos     <= addr_t'(rem << gshift);
            tail    <= addr_t'(remaining - count_t'(len));
            iss     <= '0;
            rd_pend <= 1'b0;
            state   <= ST_CHECK;
          end
          // Check the picked group is still contiguous
          ST_CHECK: begin
            rd_k <= iss;
            if (rd_pend && rd_k == '0) begin
              first <= ram_rdata;
            end
            if (rd_pend && mismatch) begin
              error_flag <= 1'b1;
              res.status <= STAT_ERR;
              rd_pend    <= 1'b0;
              state      <= ST_FINISH;
            end else if (rd_last) begin
              iss     <= '0;
              rd_pend <= 1'b0;
              state   <= ST_MOVE;
            end else begin
              if (iss_active) begin
                iss <= iss + len_t'(1);
              end
              rd_pend <= iss_active;
            end
          end
          // Copy the tail group into the picked slot
          ST_MOVE: begin
            rd_k <= iss;
            if (rd_last) begin
              rd_pend    <= 1'b0;
              remaining  <= remaining - count_t'(len);
              res.addr   <= first;
              res.len    <= len;
              res.status <= STAT_OK;
              res.last   <= (remaining == count_t'(len));
              state      <= ST_FINISH;
            end else begin
              if (iss_active) begin
                iss <= iss + len_t'(1);
              end
              rd_pend <= iss_active;
            end
          end
          // Hand the result to the output register once it is free
          ST_FINISH: begin
            if (out_load) begin
              m_tvalid <= 1'b1;
              m_tdata  <= ODATA_W'({phase_out, res.len, res.addr});
              m_tuser  <= res.status;
              m_tlast  <= res.last;
              state    <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_INIT;
          end
        endcase
      end
    end
  end

endmodule

FILE: src/rbog_ram.sv
`timescale 1ns / 1ps

module rbog_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/tb_random_block_order_generator.sv
`timescale 1ns / 1ps

module tb_random_block_order_generator;
  import rbog_pkg::*;

  localparam int          ITEMS_TARGET = 950;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam reg_idx_t    REG_UNUSED   = reg_idx_t'(1);

  // Shuffle predictor and store of expected block results
  class block_order_board;
    typedef struct packed {
      addr_t   addr;
      len_t    len;
      phase_t  phase;
      status_t status;
      logic    last;
    } block_t;

    int unsigned sect_map [MAX_SECTORS];
    int unsigned total_reg;
    int unsigned fmt_len;
    int unsigned left;
    int unsigned grp;
    int unsigned phases_rem;
    bit          halted;
    block_t      pending [$];
    int          mismatches;
    int          checked;
    int          finishing;
    int          done_seen;

    function new();
      total_reg = MAX_SECTORS;
      restart();
    endfunction

    function void restart();
      int unsigned t;
      t = (total_reg > MAX_SECTORS) ? MAX_SECTORS : total_reg;
      fmt_len = (t / ALIGN) * ALIGN;
      for (int k = 0; k < MAX_SECTORS; k++) sect_map[k] = k;
      left = fmt_len;
      grp = START_GROUP;
      phases_rem = PHASES;
      halted = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
      if (idx == REG_TOTAL) begin
        total_reg = data[SECT_W-1:0];
        restart();
      end
    endfunction

    function bit format_over();
      return halted || left == 0;
    endfunction

    // One accepted random word: pick a group, emit it, fill the hole from the tail
    function void note_word(bit [RAND_W-1:0] rnd);
      block_t      e;
      int unsigned len, groups, slot, pos, first, tail;
      bit          clash;
      e = '0;
      e.phase = phase_t'(PHASES + 1 - phases_rem);
      if (halted) begin
        e.status = STAT_ERR;
      end else if (left == 0) begin
        e.status = STAT_DONE;
      end else begin
        if (phases_rem > 1 && left <= (phases_rem - 1) * (fmt_len / PHASES)) begin
          grp = grp / 2;
          if (grp == 0) grp = 1;
          phases_rem--;
        end
        e.phase = phase_t'(PHASES + 1 - phases_rem);
        len = (grp < left) ? grp : left;
        groups = left / len;
        slot = rnd % groups;
        pos = slot * len;
        first = sect_map[pos];
        clash = 1'b0;
        for (int unsigned k = 0; k < len; k++)
          if (sect_map[pos + k] != first + k) clash = 1'b1;
        if (clash) begin
          halted = 1'b1;
          e.status = STAT_ERR;
        end else begin
          tail = left - len;
          for (int unsigned k = 0; k < len; k++) sect_map[pos + k] = sect_map[tail + k];
          left -= len;
          e.addr = addr_t'(first);
          e.len = len_t'(len);
          e.status = STAT_OK;
          e.last = (left == 0);
        end
      end
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [ODATA_W-1:0] data, logic [STAT_W-1:0] st, logic last);
      block_t e;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending, data=%h status=%0d", data, st));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.last) finishing++;
      if (e.status == STAT_DONE) done_seen++;
      if (data[ADDR_W-1:0] !== e.addr)
        report($sformatf("sector_addr %0d, want %0d", data[ADDR_W-1:0], e.addr));
      if (data[ADDR_W +: LEN_W] !== e.len)
        report($sformatf("block_sectors %0d, want %0d", data[ADDR_W +: LEN_W], e.len));
      if (data[ADDR_W+LEN_W +: PH_W] !== e.phase)
        report($sformatf("phase_number %0d, want %0d", data[ADDR_W+LEN_W +: PH_W], e.phase));
      if (data[ODATA_W-1:ADDR_W+LEN_W+PH_W] !== '0)
        report($sformatf("padding bits of tdata not zero: %h", data));
      if (st !== e.status)
        report($sformatf("status %0d, want %0d", st, e.status));
      if (last !== e.last)
        report($sformatf("tlast %b, want %b", last, e.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [RAND_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ODATA_W-1:0]   m_tdata;
  logic [STAT_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  block_order_board sb = new();
  bit               calm = 1'b0;
  int unsigned      cycles = 0;
  int               words_sent = 0;
  int               formats = 0;
  int unsigned      rx_wait = 0;

  random_block_order_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receive side: check each transfer, then toggle ready in random bursts
  always @(posedge clk) begin : rx_side
    int unsigned stall;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end else if (m_tready) begin
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        rx_wait <= stall - 1;
      end else begin
        rx_wait <= $urandom_range(0, 4);
      end
    end else begin
      m_tready <= 1'b1;
      rx_wait <= $urandom_range(0, 6);
    end
  end

  // One random word; valid stays high on return
  task automatic send_word(logic [RAND_W-1:0] rnd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= rnd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(rnd);
    words_sent++;
  endtask

  // Stop sending and let every pending result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(reg_idx_t idx, logic [PDATA_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      sb.report($sformatf("register read %0d, want %0d", prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // New device size: write it, read it back
  task automatic new_format(logic [PDATA_W-1:0] data);
    apb_write(REG_TOTAL, data);
    apb_read(REG_TOTAL, sb.total_reg);
    formats++;
  endtask

  function automatic logic [RAND_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 3);
    if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  initial begin : stimulus
    logic [RAND_W-1:0] words [7];
    int burst, n, extra;
    int unsigned kind;
    logic [PDATA_W-1:0] size;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset size: first 256-sector groups, extreme random words
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
              32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (words[i]) send_word(words[i]);
    settle();
    apb_read(REG_TOTAL, sb.total_reg);
    formats++;

    // Size above the maximum clamps
    new_format(32'h0001_FFFF);
    send_word(32'hFFFF_FFFE);
    send_word(32'h0000_0003);
    settle();

    // Too small for one group; upper write bits are dropped
    new_format(32'hFFFE_0064);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    settle();

    // Single group: one finishing block, then finished status
    new_format(32'd256);
    send_word(32'h1234_5678);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    settle();

    // Non-multiple size rounds down to two groups; spare address is ignored
    new_format(32'd767);
    send_word(32'h0000_0001);
    send_word(32'h0000_0000);
    settle();
    apb_write(REG_UNUSED, 32'd300);
    send_word(32'hDEAD_BEEF);
    settle();
    apb_read(REG_TOTAL, 32'd767);

    // Random formats, mostly run to the end
    while (words_sent < ITEMS_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 0)
        size = $urandom_range(0, 255);
      else if (kind == 1)
        size = $urandom_range(0, 131071);
      else
        size = $urandom_range(1, 10) * 256 + $urandom_range(0, 255);
      if (kind == 1)
        burst = $urandom_range(1, 16);
      else if ($urandom_range(0, 4) == 0)
        burst = $urandom_range(1, 60);
      else
        burst = 1 << 30;
      new_format(size);
      n = 0;
      while (!sb.format_over() && n < burst && words_sent < ITEMS_TARGET) begin
        if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
        send_word(pick_word());
        n++;
        if ($urandom_range(0, 80) == 0) begin
          s_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      if (sb.format_over()) begin
        extra = $urandom_range(0, 2);
        repeat (extra) send_word($urandom);
      end
      calm = 1'b0;
      settle();
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d formats, %0d random words sent, %0d blocks checked",
             formats, words_sent, sb.checked);
    $display("%0d formats completed, %0d finished-status results, %0d mismatches",
             sb.finishing, sb.done_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rbog_pkg.sv
src/rbog_ram.sv
src/random_block_order_generator.sv
sim/tb_random_block_order_generator.sv
